// ===== hdl/msp_pkg.sv =====
// Package: shared constants, codes and helpers of the Maitland-Smith pair energy block
`default_nettype none
package msp_pkg;

	localparam int FRAC_BITS = 24;
	// quotient bits of the saturating divider: anything above 63 bits saturates
	localparam int DIV_QB = 63;
	localparam int MUL_LAT = 4;
	localparam int DIV_LAT = DIV_QB + 2;
	localparam int LOG_LAT = FRAC_BITS + 1;
	localparam int EXP_LAT = FRAC_BITS + 2;
	localparam int LOG_W = FRAC_BITS + 5;

	localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;

	typedef enum logic [1:0] {
		REG_BASE,
		REG_SLOPE,
		REG_RMIN,
		REG_DEPTH
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_SAT,
		ST_INVALID
	} status_t;

	function automatic logic [63:0] mag64(input logic signed [63:0] a);
		logic [63:0] r;
		r = a[63] ? $unsigned(-a) : $unsigned(a);
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/maitland_smith_pair_energy.sv =====
// Maitland-Smith pair energy, one pair separation in and one energy out per transfer.
// Input channel: separation (unsigned Q8.24) with separation_valid / separation_stall.
// Output channel: energy (signed Q24.24, saturated) and status with result_valid /
// result_stall. Status is ok, saturated, or invalid (zero separation, zero minimum
// distance, or exponent equal to six); an invalid result carries energy zero.
// Configuration: cfg_write, cfg_index and cfg_data write m, gamma, rm and epsilon;
// write them only while no item is in flight.
// Throughput: one item per cycle while no stalled result holds the pipeline. An item passes
// through the two 65-stage bit-per-stage dividers, the 26-stage power of two unit and
// four 4-stage multipliers in series.
// The pipeline advances as a whole: a stalled result holds every stage, and
// separation_stall is high exactly while a waiting result is stalled.
// Reset clears all valid bits and loads the default shape (m 13, gamma 7, rm 1,
// epsilon 1).
`default_nettype none
module maitland_smith_pair_energy import msp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        separation_valid,
	output logic             separation_stall,
	input  wire logic [31:0] separation,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic signed [47:0] energy,
	output logic [1:0]       status,
	input  wire logic        cfg_write,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int T_X   = DIV_LAT;
	localparam int T_G   = T_X + MUL_LAT;
	localparam int T_N   = T_G + 1;
	localparam int T_NL  = T_N + MUL_LAT;
	localparam int T_EXP = T_NL + EXP_LAT;
	localparam int T_M34 = T_EXP + MUL_LAT;
	localparam int T_NUM = T_M34 + 1;
	localparam int T_Q   = T_NUM + DIV_LAT;
	localparam int T_E   = T_Q + MUL_LAT;
	localparam int T_OUT = T_E + 1;

	localparam logic signed [63:0] ONE  = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [63:0] SIX  = 64'sd6 <<< FRAC_BITS;
	localparam logic signed [63:0] ELIM = 64'sh7FFF_FFFF_FFFF;

	typedef struct packed {
		logic signed [63:0] val;
		logic               ov;
	} sval_t;

	function automatic sval_t sat_add(input logic signed [63:0] a, input logic signed [63:0] b);
		sval_t r;
		r.ov  = 1'b0;
		r.val = a + b;
		if (b > 0 && a > SMAX - b) begin
			r.val = SMAX;
			r.ov  = 1'b1;
		end else if (b < 0 && a < -SMAX - b) begin
			r.val = -SMAX;
			r.ov  = 1'b1;
		end
		return r;
	endfunction

	// configuration
	logic [29:0] base_q;
	logic [30:0] slope_q;
	logic [31:0] rmin_q;
	logic [30:0] depth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= 30'd218103808;
			slope_q <= 31'd117440512;
			rmin_q  <= 32'd16777216;
			depth_q <= 31'd16777216;
		end else if (cfg_write) begin
			unique case (reg_idx_t'(cfg_index))
				REG_BASE:  base_q  <= cfg_data[29:0];
				REG_SLOPE: slope_q <= cfg_data[30:0];
				REG_RMIN:  rmin_q  <= cfg_data;
				REG_DEPTH: depth_q <= cfg_data[30:0];
			endcase
		end
	end

	logic signed [63:0] base_v, gamma_v, rmin_v, depth_v;
	assign base_v  = $signed(64'(base_q));
	assign gamma_v = $signed({{33{slope_q[30]}}, slope_q});
	assign rmin_v  = $signed(64'(rmin_q));
	assign depth_v = $signed(64'(depth_q));

	// pipeline control: all stages advance together
	logic en;
	logic v_q [T_OUT+1];

	assign en               = !(v_q[T_OUT] && result_stall);
	assign separation_stall = !en;
	assign result_valid     = v_q[T_OUT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= T_OUT; i++) v_q[i] <= 1'b0;
		end else if (en) begin
			v_q[0] <= separation_valid;
			for (int i = 1; i <= T_OUT; i++) v_q[i] <= v_q[i-1];
		end
	end

	logic [31:0] sep_s1;
	always_ff @(posedge clk) begin
		if (en) sep_s1 <= separation;
	end

	// unit connections
	logic signed [63:0] x_v, g_v, nl_v, a_v, b_v, m3_v, m4_v, q_v, e_v;
	logic               x_ov, g_ov, nl_ov, a_ov, b_ov, m3_ov, m4_ov, q_ov, e_ov;
	logic [LOG_W-1:0]   lr_v, lm_v;
	logic signed [63:0] l_v, eb_v, ea_v, xm1_v;

	msp_div u_div_x (
		.clk(clk), .en(en), .a($signed(64'(sep_s1))), .b(rmin_v), .y(x_v), .ov(x_ov)
	);
	msp_log2 u_log_r (.clk(clk), .en(en), .v(sep_s1), .y(lr_v));
	msp_log2 u_log_m (.clk(clk), .en(en), .v(rmin_q), .y(lm_v));

	assign xm1_v = x_v - ONE;
	msp_mul u_mul_g (.clk(clk), .en(en), .a(gamma_v), .b(xm1_v), .y(g_v), .ov(g_ov));

	assign l_v = $signed(64'(lr_v)) - $signed(64'(lm_v));

	// delay lines and exponent stage
	logic               inv_d   [T_N];
	logic               ovx_d   [MUL_LAT];
	logic signed [63:0] lg_d    [T_N - LOG_LAT];
	logic signed [63:0] eb_d    [MUL_LAT];
	logic               ovn_d   [T_M34 - T_N];
	logic               ov2_d   [T_M34 - T_NL];
	logic               ovexp_d [MUL_LAT];
	logic signed [63:0] n_d     [T_EXP - T_N];
	logic signed [63:0] d_d     [T_NUM - T_N];
	logic               bad_d   [T_E - T_N];
	logic               ovnum_d [T_E - T_NUM];
	logic               ovq_d   [MUL_LAT];

	sval_t              addn, addd, addnum;
	logic signed [63:0] n_s, d_s, num_s;
	logic               ovn_s, ovnum_s;
	logic               inv0, bad_n;
	logic signed [63:0] lcur;

	assign inv0  = (sep_s1 == '0) || (rmin_q == '0);
	assign addn  = sat_add(base_v, g_v);
	assign addd  = sat_add(addn.val, -SIX);
	assign bad_n = inv_d[T_N-1] || (d_s == '0);
	assign lcur  = lg_d[T_N-LOG_LAT-1];
	assign eb_v  = -((lcur <<< 2) + (lcur <<< 1));
	assign ea_v  = -nl_v;
	assign addnum = sat_add(m3_v, -m4_v);

	always_ff @(posedge clk) begin
		if (en) begin
			inv_d[0] <= inv0;
			for (int i = 1; i < T_N; i++) inv_d[i] <= inv_d[i-1];
			ovx_d[0] <= x_ov;
			for (int i = 1; i < MUL_LAT; i++) ovx_d[i] <= ovx_d[i-1];
			lg_d[0] <= l_v;
			for (int i = 1; i < T_N - LOG_LAT; i++) lg_d[i] <= lg_d[i-1];

			n_s   <= addn.val;
			d_s   <= addd.val;
			ovn_s <= ovx_d[MUL_LAT-1] || g_ov || addn.ov || addd.ov;

			eb_d[0] <= eb_v;
			for (int i = 1; i < MUL_LAT; i++) eb_d[i] <= eb_d[i-1];
			ovn_d[0] <= ovn_s;
			for (int i = 1; i < T_M34 - T_N; i++) ovn_d[i] <= ovn_d[i-1];
			n_d[0] <= n_s;
			for (int i = 1; i < T_EXP - T_N; i++) n_d[i] <= n_d[i-1];
			d_d[0] <= d_s;
			for (int i = 1; i < T_NUM - T_N; i++) d_d[i] <= d_d[i-1];
			bad_d[0] <= bad_n;
			for (int i = 1; i < T_E - T_N; i++) bad_d[i] <= bad_d[i-1];

			ov2_d[0] <= nl_ov;
			for (int i = 1; i < T_M34 - T_NL; i++) ov2_d[i] <= ov2_d[i-1];
			ovexp_d[0] <= a_ov || b_ov;
			for (int i = 1; i < MUL_LAT; i++) ovexp_d[i] <= ovexp_d[i-1];

			num_s   <= addnum.val;
			ovnum_s <= ovn_d[T_M34-T_N-1] || ov2_d[T_M34-T_NL-1] || ovexp_d[MUL_LAT-1]
				|| m3_ov || m4_ov || addnum.ov;

			ovnum_d[0] <= ovnum_s;
			for (int i = 1; i < T_E - T_NUM; i++) ovnum_d[i] <= ovnum_d[i-1];
			ovq_d[0] <= q_ov;
			for (int i = 1; i < MUL_LAT; i++) ovq_d[i] <= ovq_d[i-1];
		end
	end

	msp_mul u_mul_nl (.clk(clk), .en(en), .a(n_s), .b(lcur), .y(nl_v), .ov(nl_ov));
	msp_exp2 u_exp_a (.clk(clk), .en(en), .e(ea_v), .y(a_v), .ov(a_ov));
	msp_exp2 u_exp_b (.clk(clk), .en(en), .e(eb_d[MUL_LAT-1]), .y(b_v), .ov(b_ov));
	msp_mul u_mul_a (.clk(clk), .en(en), .a(SIX), .b(a_v), .y(m3_v), .ov(m3_ov));
	msp_mul u_mul_b (
		.clk(clk), .en(en), .a(n_d[T_EXP-T_N-1]), .b(b_v), .y(m4_v), .ov(m4_ov)
	);
	msp_div u_div_q (
		.clk(clk), .en(en), .a(num_s), .b(d_d[T_NUM-T_N-1]), .y(q_v), .ov(q_ov)
	);
	msp_mul u_mul_e (.clk(clk), .en(en), .a(depth_v), .b(q_v), .y(e_v), .ov(e_ov));

	// clamp to the output range and form the status
	logic               hi_c, lo_c, ov_all;
	logic signed [47:0] e_c;

	assign hi_c   = e_v > ELIM;
	assign lo_c   = e_v < -ELIM - 64'sd1;
	assign ov_all = ovnum_d[T_E-T_NUM-1] || ovq_d[MUL_LAT-1] || e_ov || hi_c || lo_c;

	always_comb begin
		priority if (hi_c) e_c = ELIM[47:0];
		else if (lo_c) e_c = ~ELIM[47:0];
		else e_c = e_v[47:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (bad_d[T_E-T_N-1]) begin
				energy <= '0;
				status <= ST_INVALID;
			end else begin
				energy <= e_c;
				status <= ov_all ? ST_SAT : ST_OK;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/msp_mul.sv =====
// Saturating fixed-point multiplier: (a*b) >> FRAC_BITS, four register stages
`default_nettype none
module msp_mul import msp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [63:0] a,
	input  wire logic signed [63:0] b,
	output logic signed [63:0]      y,
	output logic                    ov
);

	logic [63:0]  ua_s1, ub_s1;
	logic         neg_s1, neg_s2, neg_s3;
	logic [63:0]  p00_s2, p01_s2, p10_s2, p11_s2;
	logic [127:0] prod_s3;
	logic [63:0]  res;
	logic         hi_ov;
	logic [63:0]  mag_v;

	always_ff @(posedge clk) begin
		if (en) begin
			ua_s1  <= mag64(a);
			ub_s1  <= mag64(b);
			neg_s1 <= a[63] ^ b[63];
			p00_s2 <= ua_s1[31:0] * ub_s1[31:0];
			p01_s2 <= ua_s1[31:0] * ub_s1[63:32];
			p10_s2 <= ua_s1[63:32] * ub_s1[31:0];
			p11_s2 <= ua_s1[63:32] * ub_s1[63:32];
			neg_s2 <= neg_s1;
			prod_s3 <= {64'b0, p00_s2} + {32'b0, p01_s2, 32'b0} + {32'b0, p10_s2, 32'b0}
				+ {p11_s2, 64'b0};
			neg_s3 <= neg_s2;
			y  <= neg_s3 ? -$signed(mag_v) : $signed(mag_v);
			ov <= hi_ov;
		end
	end

	// anything at or above bit 63 of the scaled product saturates
	assign res   = prod_s3[FRAC_BITS +: 64];
	assign hi_ov = |prod_s3[127:63+FRAC_BITS];
	assign mag_v = hi_ov ? $unsigned(SMAX) : res;

endmodule
`default_nettype wire

// ===== hdl/msp_div.sv =====
// Saturating fixed-point divider: (a << FRAC_BITS) / b, one quotient bit per stage
`default_nettype none
module msp_div import msp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [63:0] a,
	input  wire logic signed [63:0] b,
	output logic signed [63:0]      y,
	output logic                    ov
);

	localparam int NB = 64 + FRAC_BITS;

	logic [63:0]       ua, ub;
	logic [NB-1:0]     num;
	logic [63:0]       ub_s  [DIV_QB+1];
	logic [63:0]       rem_s [DIV_QB+1];
	logic [DIV_QB-1:0] dig_s [DIV_QB+1];
	logic [DIV_QB-1:0] quo_s [DIV_QB+1];
	logic              neg_s [DIV_QB+1];
	logic              ovf_s [DIV_QB+1];
	logic [63:0]       magq;

	assign ua  = mag64(a);
	assign ub  = mag64(b);
	assign num = {ua, {FRAC_BITS{1'b0}}};

	// quotient overflows 63 bits exactly when a >= b * 2^(63-F)
	always_ff @(posedge clk) begin
		if (en) begin
			ub_s[0]  <= ub;
			rem_s[0] <= 64'(num[NB-1:DIV_QB]);
			dig_s[0] <= num[DIV_QB-1:0];
			quo_s[0] <= '0;
			neg_s[0] <= a[63] ^ b[63];
			ovf_s[0] <= (ua >> (DIV_QB - FRAC_BITS)) >= ub;
		end
	end

	for (genvar j = 0; j < DIV_QB; j++) begin : g_step
		logic [64:0] trial;
		logic        ge;
		assign trial = {rem_s[j], dig_s[j][DIV_QB-1]};
		assign ge    = trial >= {1'b0, ub_s[j]};
		always_ff @(posedge clk) begin
			if (en) begin
				ub_s[j+1]  <= ub_s[j];
				rem_s[j+1] <= ge ? 64'(trial - {1'b0, ub_s[j]}) : trial[63:0];
				dig_s[j+1] <= dig_s[j] << 1;
				quo_s[j+1] <= {quo_s[j][DIV_QB-2:0], ge};
				neg_s[j+1] <= neg_s[j];
				ovf_s[j+1] <= ovf_s[j];
			end
		end
	end

	assign magq = ovf_s[DIV_QB] ? $unsigned(SMAX) : 64'(quo_s[DIV_QB]);

	always_ff @(posedge clk) begin
		if (en) begin
			y  <= neg_s[DIV_QB] ? -$signed(magq) : $signed(magq);
			ov <= ovf_s[DIV_QB];
		end
	end

endmodule
`default_nettype wire

// ===== hdl/msp_log2.sv =====
// Base-2 logarithm of a raw 32-bit value by repeated squaring, one fraction bit per stage
`default_nettype none
module msp_log2 import msp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] v,
	output logic [LOG_W-1:0] y
);

	logic [4:0]           p;
	logic [63:0]          mfull;
	logic [31:0]          m_s    [FRAC_BITS+1];
	logic [FRAC_BITS-1:0] frac_s [FRAC_BITS+1];
	logic [4:0]           p_s    [FRAC_BITS+1];

	// leading one position; zero input gives position zero
	always_comb begin
		p = '0;
		for (int i = 1; i < 32; i++) begin
			if (v[i]) p = 5'(i);
		end
	end

	assign mfull = ({32'b0, v} << 31) >> p;

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0]    <= mfull[31:0];
			frac_s[0] <= '0;
			p_s[0]    <= p;
		end
	end

	for (genvar i = 0; i < FRAC_BITS; i++) begin : g_sq
		logic [63:0] sq;
		logic [32:0] t;
		assign sq = m_s[i] * m_s[i];
		assign t  = sq[63:31];
		always_ff @(posedge clk) begin
			if (en) begin
				m_s[i+1]    <= t[32] ? t[32:1] : t[31:0];
				frac_s[i+1] <= {frac_s[i][FRAC_BITS-2:0], t[32]};
				p_s[i+1]    <= p_s[i];
			end
		end
	end

	assign y = {p_s[FRAC_BITS], frac_s[FRAC_BITS]};

endmodule
`default_nettype wire

// ===== hdl/msp_exp2.sv =====
// Power of two of a signed fixed-point argument: product of root constants, then shift
`default_nettype none
module msp_exp2 import msp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [63:0] e,
	output logic signed [63:0]      y,
	output logic                    ov
);

	localparam int EXP_OFS = 30 - FRAC_BITS;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] rem, res, bits;
		rem  = v;
		res  = '0;
		bits = 64'd1 << 62;
		for (int j = 0; j < 32; j++) begin
			if (bits > rem) bits = bits >> 2;
		end
		for (int j = 0; j < 32; j++) begin
			if (bits != 0) begin
				if (rem >= res + bits) begin
					rem = rem - (res + bits);
					res = (res >> 1) + bits;
				end else begin
					res = res >> 1;
				end
				bits = bits >> 2;
			end
		end
		return res;
	endfunction

	// 2^(2^-i) in Q.30 by successive floor square roots from 2
	function automatic logic [30:0] exp2_root(input int i);
		logic [63:0] c;
		c = 64'd1 << 31;
		for (int j = 1; j <= i; j++) c = isqrt64(c << 30);
		return c[30:0];
	endfunction

	logic [63:0]           ue;
	logic [FRAC_BITS-1:0]  fr, f;
	logic [63-FRAC_BITS:0] ip;
	logic signed [65:0]    k, s;
	logic [30:0]           p_s   [FRAC_BITS+1];
	logic [FRAC_BITS-1:0]  f_s   [FRAC_BITS+1];
	logic                  big_s [FRAC_BITS+1];
	logic                  tiny_s[FRAC_BITS+1];
	logic signed [6:0]     sh_s  [FRAC_BITS+1];
	logic signed [6:0]     sh;
	logic [5:0]            nsh;

	assign ue = mag64(e);
	assign fr = ue[FRAC_BITS-1:0];
	assign ip = ue[63:FRAC_BITS];

	// floor and fraction of the argument
	always_comb begin
		if (!e[63]) begin
			k = $signed(66'(ip));
			f = fr;
		end else if (fr == '0) begin
			k = -$signed(66'(ip));
			f = '0;
		end else begin
			k = -$signed(66'(ip)) - 66'sd1;
			f = -fr;
		end
		s = k - EXP_OFS;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s[0]    <= 31'(1) << 30;
			f_s[0]    <= f;
			big_s[0]  <= s > 66'sd32;
			tiny_s[0] <= s <= -66'sd63;
			sh_s[0]   <= s[6:0];
		end
	end

	for (genvar i = 0; i < FRAC_BITS; i++) begin : g_fac
		localparam logic [30:0] ROOT = exp2_root(i + 1);
		logic [61:0] prod;
		assign prod = p_s[i] * ROOT;
		always_ff @(posedge clk) begin
			if (en) begin
				p_s[i+1]    <= f_s[i][FRAC_BITS-1] ? prod[60:30] : p_s[i];
				f_s[i+1]    <= f_s[i] << 1;
				big_s[i+1]  <= big_s[i];
				tiny_s[i+1] <= tiny_s[i];
				sh_s[i+1]   <= sh_s[i];
			end
		end
	end

	assign sh  = sh_s[FRAC_BITS];
	assign nsh = 6'(-sh);

	always_ff @(posedge clk) begin
		if (en) begin
			ov <= big_s[FRAC_BITS];
			priority if (big_s[FRAC_BITS]) begin
				y <= SMAX;
			end else if (tiny_s[FRAC_BITS]) begin
				y <= '0;
			end else if (!sh[6]) begin
				y <= $signed(64'(p_s[FRAC_BITS]) << sh[5:0]);
			end else begin
				y <= $signed(64'(p_s[FRAC_BITS]) >> nsh);
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/msp_chk.sv =====
// Port-level checker for the Maitland-Smith pair energy block, bound to the top level
`default_nettype none
module msp_chk import msp_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        separation_valid,
	input wire logic        separation_stall,
	input wire logic [31:0] separation,
	input wire logic        result_valid,
	input wire logic        result_stall,
	input wire logic signed [47:0] energy,
	input wire logic [1:0]  status,
	input wire logic        cfg_write,
	input wire logic [1:0]  cfg_index,
	input wire logic [31:0] cfg_data
);

	// input backpressure comes only from a waiting, stalled result
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		separation_stall |-> (result_valid && result_stall))
		else $error("input stalled without a stalled result");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status == ST_INVALID) |-> (energy == 48'sd0))
		else $error("invalid result carries nonzero energy");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(energy) && $stable(status)))
		else $error("stalled result changed");

endmodule

bind maitland_smith_pair_energy msp_chk u_msp_chk (.*);
`default_nettype wire
